@@ sv/pcd_pkg.sv @@
// Shared types, constants and helpers for the prefix code table decoder.
package pcd_pkg;

    localparam int CODE_BITS = 16;
    localparam int LEN_BITS  = 5;
    localparam int SYM_BITS  = 8;
    localparam int IDX_BITS  = 8;
    localparam int CNT_BITS  = 9;

    localparam logic [LEN_BITS-1:0] MAX_CODE_BITS = LEN_BITS'(CODE_BITS);

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam logic REG_ENTRY_COUNT    = 1'b0;
    localparam logic REG_LONGEST_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [CODE_BITS-1:0] code;
        logic [LEN_BITS-1:0]  len;
        logic [SYM_BITS-1:0]  sym;
    } t_entry;

    typedef struct packed {
        logic clear;
        logic dvld;
    } t_srch_ctl;

    typedef struct packed {
        logic                found;
        logic [LEN_BITS-1:0] len;
        logic [SYM_BITS-1:0] sym;
    } t_srch_res;

    function automatic logic [LEN_BITS-1:0] clamp_len(input logic [LEN_BITS-1:0] len);
        return (len > MAX_CODE_BITS) ? MAX_CODE_BITS : len;
    endfunction

    function automatic logic [CODE_BITS-1:0] ones_below(input logic [CODE_BITS-1:0] value,
                                                        input logic [LEN_BITS-1:0]  len);
        logic [LEN_BITS-1:0] l;
        l = clamp_len(len);
        return value | ({CODE_BITS{1'b1}} >> l);
    endfunction

endpackage

@@ sv/pcd_table_mem.sv @@
// Table memory: one write port, one registered read port.
module pcd_table_mem
    import pcd_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/pcd_search.sv @@
// Running search for the least stored code not below the window.
module pcd_search
    import pcd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_srch_ctl            i_ctl,
    input  logic [CODE_BITS-1:0] i_window,
    input  t_entry               i_entry,
    output t_srch_res            o_res
);

    logic                 r_found;
    logic [CODE_BITS-1:0] r_best_code;
    logic [LEN_BITS-1:0]  r_best_len;
    logic [SYM_BITS-1:0]  r_best_sym;
    logic                 take;

    assign take = i_ctl.dvld && (i_entry.code >= i_window)
               && (!r_found || (i_entry.code < r_best_code));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best_code <= i_entry.code;
            r_best_len  <= i_entry.len;
            r_best_sym  <= i_entry.sym;
        end
    end

    assign o_res.found = r_found;
    assign o_res.len   = r_best_len;
    assign o_res.sym   = r_best_sym;

endmodule

@@ sv/prefix_code_table_decoder.sv @@
// Top level: table load, configuration and sequenced search over the table memory.
//
//   channel   direction  handshake                    payload
//   item      in         start & !busy                i_opcode, i_entry_*, i_bit_window
//   result    out        o_done (one-cycle strobe)    o_symbol, o_consumed_length, o_miss
//   config    in         i_cfg_valid & o_cfg_ready    i_cfg_index, i_cfg_data
//
// A write item is stored as it is accepted. A decode item scans N entries, N being
// entry_count clamped to TABLE_ENTRIES (straight to the result when N is zero): one
// table read per cycle on the single memory read port, then the drain state and the
// result cycle, in which the next item may already be accepted. Reset is synchronous
// and active low; the table is not cleared. The result cannot be stalled.
module prefix_code_table_decoder
    import pcd_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_opcode,
    input  logic [IDX_BITS-1:0]  i_entry_index,
    input  logic [CODE_BITS-1:0] i_entry_code,
    input  logic [LEN_BITS-1:0]  i_entry_length,
    input  logic [SYM_BITS-1:0]  i_entry_symbol,
    input  logic [CODE_BITS-1:0] i_bit_window,
    output logic                 o_done,
    output logic [SYM_BITS-1:0]  o_symbol,
    output logic [LEN_BITS-1:0]  o_consumed_length,
    output logic                 o_miss,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [CNT_BITS-1:0]  i_cfg_data
);

    localparam int AW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CWT = $clog2(TABLE_ENTRIES + 1);
    localparam int CW  = (CWT > CNT_BITS) ? CWT : CNT_BITS;

    t_state               r_state;
    t_state               n_state;
    logic [CNT_BITS-1:0]  r_entry_count;
    logic [LEN_BITS-1:0]  r_longest_length;
    logic [CODE_BITS-1:0] r_window;
    logic [CW-1:0]        r_limit;
    logic [CW-1:0]        n_limit;
    logic [AW-1:0]        r_addr;
    logic                 r_dvld;
    logic                 accept;
    logic                 acc_dec;
    logic                 acc_wr;
    logic                 last_read;
    logic                 mem_re;
    logic                 in_range;
    t_entry               wr_entry;
    t_entry               rd_entry;
    t_srch_ctl            srch_ctl;
    t_srch_res            srch_res;

    assign accept    = start && !busy;
    assign acc_dec   = accept && (i_opcode == OP_DECODE);
    assign acc_wr    = accept && (i_opcode == OP_WRITE);
    assign in_range  = 32'(i_entry_index) < 32'(TABLE_ENTRIES);
    assign last_read = (CW'(r_addr) == (r_limit - CW'(1)));
    assign n_limit   = (CW'(r_entry_count) > CW'(TABLE_ENTRIES)) ? CW'(TABLE_ENTRIES)
                                                                 : CW'(r_entry_count);

    assign wr_entry.code = ones_below(i_entry_code, i_entry_length);
    assign wr_entry.len  = clamp_len(i_entry_length);
    assign wr_entry.sym  = i_entry_symbol;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count    <= '0;
            r_longest_length <= MAX_CODE_BITS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_ENTRY_COUNT:    r_entry_count    <= i_cfg_data;
                REG_LONGEST_LENGTH: r_longest_length <= i_cfg_data[LEN_BITS-1:0];
                default:            r_entry_count    <= r_entry_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_dvld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dvld  <= mem_re;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_dec) begin
            r_window <= ones_below(i_bit_window, r_longest_length);
            r_limit  <= n_limit;
            r_addr   <= '0;
        end else if (mem_re) begin
            r_addr <= r_addr + AW'(1);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state) inside
            ST_IDLE, ST_DONE: begin
                if (acc_dec) begin
                    n_state = (n_limit == '0) ? ST_DONE : ST_SCAN;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (last_read) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_DONE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy   = 1'b1;
        o_done = 1'b0;
        mem_re = 1'b0;
        unique case (r_state)
            ST_IDLE:  busy = 1'b0;
            ST_SCAN:  mem_re = 1'b1;
            ST_DRAIN: busy = 1'b1;
            ST_DONE: begin
                busy   = 1'b0;
                o_done = 1'b1;
            end
            default:  busy = 1'b1;
        endcase
    end

    assign o_miss            = !srch_res.found;
    assign o_symbol          = srch_res.found ? srch_res.sym : '0;
    assign o_consumed_length = srch_res.found ? srch_res.len : '0;

    assign srch_ctl.clear = acc_dec;
    assign srch_ctl.dvld  = r_dvld;

    pcd_table_mem #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (acc_wr && in_range),
        .i_waddr (AW'(i_entry_index)),
        .i_wdata (wr_entry),
        .i_re    (mem_re),
        .i_raddr (r_addr),
        .o_rdata (rd_entry)
    );

    pcd_search u_search (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (srch_ctl),
        .i_window (r_window),
        .i_entry  (rd_entry),
        .o_res    (srch_res)
    );

`ifndef SYNTHESIS
    a_dec_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_dec && (n_limit != '0) |=> busy && !o_done)
        else $error("decode did not start scanning");

    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done || $past(acc_dec))
        else $error("result repeated without a new decode");

    a_dvld_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dvld |-> $past(r_state == ST_SCAN))
        else $error("read data flagged outside a scan");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_miss |-> (o_symbol == '0) && (o_consumed_length == '0))
        else $error("miss result carries data");

    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_re |-> !acc_wr)
        else $error("table write during scan");
`endif

endmodule

@@ bench/prefix_code_table_decoder_tb.sv @@
// Self-checking bench for the prefix code table decoder: canonical tables, decodes, registers.
module prefix_code_table_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pcd_pkg::*;

    localparam int ITEMS_TARGET = 1350;
    localparam int TABLE_SLOTS  = 256;

    typedef struct packed {
        logic [SYM_BITS-1:0] sym;
        logic [LEN_BITS-1:0] len;
        logic                miss;
    } t_decode_result;

    class t_table_checker;
        logic [CODE_BITS-1:0] filled_code [TABLE_SLOTS];
        logic [LEN_BITS-1:0]  code_len [TABLE_SLOTS];
        logic [SYM_BITS-1:0]  code_sym [TABLE_SLOTS];
        logic [CNT_BITS-1:0]  entry_count;
        logic [LEN_BITS-1:0]  longest_len;
        t_decode_result       pending_decodes [$];
        int                   mismatches;

        function new();
            entry_count = '0;
            longest_len = MAX_CODE_BITS;
            mismatches  = 0;
        endfunction

        function logic [LEN_BITS-1:0] cap_len(logic [LEN_BITS-1:0] l);
            return (l > CODE_BITS) ? LEN_BITS'(CODE_BITS) : l;
        endfunction

        function logic [CODE_BITS-1:0] fill_tail(logic [CODE_BITS-1:0] v,
                                                 logic [LEN_BITS-1:0] l);
            int n;
            n = int'(cap_len(l));
            return v | CODE_BITS'((32'd1 << (CODE_BITS - n)) - 1);
        endfunction

        function void set_register(logic idx, logic [CNT_BITS-1:0] data);
            if (idx == REG_ENTRY_COUNT) begin
                entry_count = data;
            end else begin
                longest_len = data[LEN_BITS-1:0];
            end
        endfunction

        function void note_item(logic op, logic [IDX_BITS-1:0] idx,
                                logic [CODE_BITS-1:0] code, logic [LEN_BITS-1:0] len,
                                logic [SYM_BITS-1:0] sym, logic [CODE_BITS-1:0] win);
            t_decode_result       want;
            logic [CODE_BITS-1:0] window;
            logic [CODE_BITS-1:0] best;
            int                   top;
            bit                   hit;
            if (op == OP_WRITE) begin
                filled_code[idx] = fill_tail(code, len);
                code_len[idx]    = cap_len(len);
                code_sym[idx]    = sym;
                return;
            end
            window = fill_tail(win, longest_len);
            top = (entry_count > TABLE_SLOTS) ? TABLE_SLOTS : int'(entry_count);
            hit = 1'b0;
            best = '0;
            want = '0;
            want.miss = 1'b1;
            for (int i = 0; i < top; i++) begin
                if (filled_code[i] >= window && (!hit || filled_code[i] < best)) begin
                    hit = 1'b1;
                    best = filled_code[i];
                    want.sym = code_sym[i];
                    want.len = code_len[i];
                    want.miss = 1'b0;
                end
            end
            pending_decodes = {pending_decodes, want};
        endfunction

        function void check_decode(logic [SYM_BITS-1:0] sym, logic [LEN_BITS-1:0] len,
                                   logic miss);
            t_decode_result want;
            if (pending_decodes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result with no decode pending: symbol %0h length %0d miss %0b",
                             sym, len, miss);
                end
                return;
            end
            want = pending_decodes.pop_front();
            if (sym !== want.sym || len !== want.len || miss !== want.miss) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display({"decode mismatch: expected symbol %0h length %0d miss %0b,",
                              " got symbol %0h length %0d miss %0b"},
                             want.sym, want.len, want.miss, sym, len, miss);
                end
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic                 i_opcode;
    logic [IDX_BITS-1:0]  i_entry_index;
    logic [CODE_BITS-1:0] i_entry_code;
    logic [LEN_BITS-1:0]  i_entry_length;
    logic [SYM_BITS-1:0]  i_entry_symbol;
    logic [CODE_BITS-1:0] i_bit_window;
    logic                 o_done;
    logic [SYM_BITS-1:0]  o_symbol;
    logic [LEN_BITS-1:0]  o_consumed_length;
    logic                 o_miss;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic                 i_cfg_index;
    logic [CNT_BITS-1:0]  i_cfg_data;

    t_table_checker chk = new();
    int items_sent = 0;

    prefix_code_table_decoder dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_opcode          (i_opcode),
        .i_entry_index     (i_entry_index),
        .i_entry_code      (i_entry_code),
        .i_entry_length    (i_entry_length),
        .i_entry_symbol    (i_entry_symbol),
        .i_bit_window      (i_bit_window),
        .o_done            (o_done),
        .o_symbol          (o_symbol),
        .o_consumed_length (o_consumed_length),
        .o_miss            (o_miss),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            chk.check_decode(o_symbol, o_consumed_length, o_miss);
        end
    end

    function automatic int idle_pct();
        if (items_sent < ITEMS_TARGET / 3) return 28;
        if (items_sent < 2 * ITEMS_TARGET / 3) return 50;
        return 0;
    endfunction

    task automatic send_item(input logic op, input logic [IDX_BITS-1:0] idx,
                             input logic [CODE_BITS-1:0] code, input logic [LEN_BITS-1:0] len,
                             input logic [SYM_BITS-1:0] sym, input logic [CODE_BITS-1:0] win);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct()) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_opcode       <= op;
        i_entry_index  <= idx;
        i_entry_code   <= code;
        i_entry_length <= len;
        i_entry_symbol <= sym;
        i_bit_window   <= win;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        chk.note_item(op, idx, code, len, sym, win);
        items_sent++;
    endtask

    task automatic send_write(input logic [IDX_BITS-1:0] idx, input logic [CODE_BITS-1:0] code,
                              input logic [LEN_BITS-1:0] len, input logic [SYM_BITS-1:0] sym);
        send_item(OP_WRITE, idx, code, len, sym, CODE_BITS'($urandom));
    endtask

    task automatic send_decode(input logic [CODE_BITS-1:0] win);
        send_item(OP_DECODE, IDX_BITS'($urandom), CODE_BITS'($urandom), LEN_BITS'($urandom),
                  SYM_BITS'($urandom), win);
    endtask

    // hold off until every decode has answered and the block has settled
    task automatic wait_for_quiet();
        start <= 1'b0;
        while (chk.pending_decodes.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [CNT_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        chk.set_register(idx, data);
    endtask

    task automatic set_registers(input logic [CNT_BITS-1:0] count,
                                 input logic [CNT_BITS-1:0] longest);
        cfg_write(REG_ENTRY_COUNT, count);
        cfg_write(REG_LONGEST_LENGTH, longest);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int                  n, nc, lg, eff, cur, nxt, k, tmp, r, ndec, lval, phase;
        int                  perm [TABLE_SLOTS];
        int                  slot_code [TABLE_SLOTS];
        int                  slot_len [TABLE_SLOTS];
        logic [CNT_BITS-1:0] ldata;
        logic [LEN_BITS-1:0] wlen;

        start          <= 1'b0;
        i_opcode       <= OP_WRITE;
        i_entry_index  <= '0;
        i_entry_code   <= '0;
        i_entry_length <= '0;
        i_entry_symbol <= '0;
        i_bit_window   <= '0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= REG_ENTRY_COUNT;
        i_cfg_data     <= '0;
        i_rst_n        <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table: every decode misses
        set_registers(9'd0, 9'd16);
        send_decode(16'h0000);
        send_decode(16'hFFFF);

        send_write(8'd0, 16'h0000, 5'd1, 8'h11);
        send_write(8'd1, 16'h8000, 5'd16, 8'hFF);
        send_write(8'd2, 16'hFFFF, 5'd0, 8'h00);
        send_write(8'd3, 16'hC000, 5'd31, 8'hA5);
        send_write(8'd4, 16'hC000, 5'd16, 8'h5A);
        send_write(8'd255, 16'hFFFF, 5'd16, 8'h80);

        wait_for_quiet();
        set_registers(9'd5, 9'd16);
        send_decode(16'h0000);
        send_decode(16'h8000);
        send_decode(16'h8001);
        send_decode(16'hC000);
        send_decode(16'hFFFF);

        wait_for_quiet();
        set_registers(9'd5, 9'd0);
        send_decode(16'h1234);

        wait_for_quiet();
        set_registers(9'd5, 9'h1FF);
        send_decode(16'h4000);

        wait_for_quiet();
        set_registers(9'd5, 9'd1);
        send_decode(16'h4000);
        send_decode(16'h8000);

        phase = 0;
        while (items_sent < ITEMS_TARGET) begin
            r = $urandom_range(0, 99);
            if (phase == 0) begin
                n = 511;
            end else if (phase == 1) begin
                n = 256;
            end else if (r < 2) begin
                n = 0;
            end else if (r < 5) begin
                n = $urandom_range(256, 511);
            end else if (r < 20) begin
                n = $urandom_range(17, 64);
            end else begin
                n = $urandom_range(1, 16);
            end
            nc = (n > TABLE_SLOTS) ? TABLE_SLOTS : n;

            r = $urandom_range(0, 9);
            if (r == 0) begin
                lval = 0;
            end else if (r == 1) begin
                lval = $urandom_range(17, 31);
            end else begin
                lval = $urandom_range((nc > 1) ? $clog2(nc) : 1, 16);
            end
            ldata = CNT_BITS'(lval);
            if ($urandom_range(0, 4) == 0) ldata[CNT_BITS-1:LEN_BITS] = 4'($urandom);
            eff = (lval > CODE_BITS) ? CODE_BITS : lval;
            lg = (eff == 0 || (1 << eff) < nc) ? CODE_BITS : eff;

            wait_for_quiet();
            set_registers(CNT_BITS'(n), ldata);

            // canonical code, lengths nondecreasing, spread over shuffled slots
            for (int i = 0; i < nc; i++) perm[i] = i;
            for (int i = nc - 1; i > 0; i--) begin
                k = $urandom_range(0, i);
                tmp = perm[i];
                perm[i] = perm[k];
                perm[k] = tmp;
            end
            cur = 1;
            nxt = 0;
            for (int i = 0; i < nc; i++) begin
                if (cur < lg && $urandom_range(0, 3) == 0) begin
                    cur++;
                    nxt <<= 1;
                end
                while (cur < lg &&
                       (nxt << (lg - cur)) + (1 << (lg - cur)) + (nc - i) - 1 > (1 << lg)) begin
                    cur++;
                    nxt <<= 1;
                end
                slot_len[perm[i]] = cur;
                slot_code[perm[i]] = nxt << (CODE_BITS - cur);
                nxt++;
                wlen = LEN_BITS'(cur);
                if (cur == CODE_BITS && $urandom_range(0, 1) == 1) begin
                    wlen = LEN_BITS'($urandom_range(16, 31));
                end
                send_write(IDX_BITS'(perm[i]), CODE_BITS'(slot_code[perm[i]]), wlen,
                           SYM_BITS'($urandom));
            end

            ndec = $urandom_range(15, 40);
            for (int j = 0; j < ndec; j++) begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    send_write(IDX_BITS'((r < 4 && nc > 0) ? $urandom_range(0, nc - 1)
                                                            : $urandom),
                               CODE_BITS'($urandom), LEN_BITS'($urandom), SYM_BITS'($urandom));
                end else if (r < 10) begin
                    wait_for_quiet();
                end else if (r < 25 || nc == 0) begin
                    send_decode(CODE_BITS'($urandom));
                end else begin
                    k = $urandom_range(0, nc - 1);
                    tmp = (1 << (CODE_BITS - slot_len[k])) - 1;
                    send_decode(CODE_BITS'(slot_code[k] | ((r < 40) ? 0 : ($urandom & tmp))));
                end
            end
            phase++;
        end

        wait_for_quiet();
        repeat (300) @(posedge i_clk);
        if (chk.mismatches == 0 && chk.pending_decodes.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
